// ===== hdl/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define BCPD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define BCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bcpd_pkg.sv =====
// shared types, constants and byte classing for the pixel downsampler
package bcpd_pkg;

   localparam int NUM_LANES  = 3;
   localparam int SUM_W      = 24;
   localparam int COUNT_W    = 16;
   localparam int INDEX_W    = 24;
   localparam int CHAN_W     = 8;
   localparam int DIV_STEPS  = 8;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] LANE_RED   = 2'd0;
   localparam logic [1:0] LANE_GREEN = 2'd1;
   localparam logic [1:0] LANE_BLUE  = 2'd2;

   // register indexes of the configuration port
   localparam logic CSR_GROUP_SIZE = 1'b0;
   localparam logic CSR_CLASS_MODE = 1'b1;

   localparam logic [7:0] CLASS_ADD  = 8'hF0;
   localparam logic [7:0] WHITE_ADD  = 8'hFF;
   localparam logic [7:0] BLUE_TOP   = 8'h1F;
   localparam logic [7:0] GREEN_TOP  = 8'h7F;
   localparam logic [7:0] WHITE_CODE = 8'hFF;
   localparam logic [7:0] PLAIN_FILL = 8'd20;
   localparam logic [7:0] CHAN_MAX   = 8'hFF;

   typedef logic [NUM_LANES-1:0][CHAN_W-1:0] lane_add_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_first;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic emit;
   } dp_status_type;

   // per-channel increment of one byte in class mode
   function automatic lane_add_type class_add(input logic [7:0] value);
      lane_add_type add;
      add = '0;
      if (value == 8'h00) begin
         add = '0;
      end else if (value <= BLUE_TOP) begin
         add[LANE_BLUE] = CLASS_ADD;
      end else if (value <= GREEN_TOP) begin
         add[LANE_GREEN] = CLASS_ADD;
      end else if (value != WHITE_CODE) begin
         add[LANE_RED] = CLASS_ADD;
      end else begin
         add[LANE_RED]   = WHITE_ADD;
         add[LANE_GREEN] = WHITE_ADD;
         add[LANE_BLUE]  = WHITE_ADD;
      end
      return add;
   endfunction

endpackage

// ===== hdl/byte_class_pixel_downsampler.sv =====
// top level of the byte class pixel downsampler
// Bytes come in one transaction at a time and are summed per color channel until a run
// of group_size bytes is complete (a group size of zero acts as one, larger sizes saturate
// at MAX_GROUP), or until a byte flagged end_of_data closes a short run and restarts the
// pixel index at zero. A byte that does not close a run is taken and the next one can
// follow right away. A byte that closes a run holds off further bytes until its pixel is
// handed on: it is accumulated, then the shared three-lane restoring divider runs (an
// overflow check, then one quotient bit per cycle for eight bits), and the pixel is
// handed to the output register. The output register keeps the finished pixel while the
// consumer stalls, so bytes of the next run keep flowing; only the handoff of the next
// finished pixel waits for the register to drain, and intake stalls while it waits.
`include "assert_macros.svh"

module byte_class_pixel_downsampler #(
   parameter int MAX_GROUP = 65535
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   // byte stream
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_data,
   // pixel stream
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [23:0] rsp_pixel_index
);

   bcpd_pkg::ctrl_cmd_type  cmd;
   bcpd_pkg::dp_status_type sts;

   // sequencer: intake, divider steps, result handoff
   bcpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // sums, divider lanes and pixel register
   bcpd_datapath #(
      .MAX_GROUP (MAX_GROUP)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_byte_value   (req_byte_value),
      .req_end_of_data  (req_end_of_data),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_pixel_index  (rsp_pixel_index)
   );

   // a run-closing transaction must block intake while the divider works
   `BCPD_ASSERT_NEXT(a_busy_after_close, req_valid && !req_stall && sts.emit, req_stall, "intake open while divider busy")
   // the pixel register is never overwritten while a pixel still waits
   `BCPD_ASSERT_NOW(a_no_overwrite, cmd.out_load, !rsp_valid || !rsp_stall, "pending pixel overwritten")
   // a new pixel only appears after a handoff from the divider
   `BCPD_ASSERT_NOW(a_valid_from_load, $rose(rsp_valid), $past(cmd.out_load), "pixel valid without handoff")

endmodule

// ===== hdl/bcpd_ctrl.sv =====
// controller state machine: byte intake, divider sequencing, result handoff
module bcpd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  bcpd_pkg::dp_status_type sts,
   output bcpd_pkg::ctrl_cmd_type  cmd
);

   bcpd_pkg::state_type                 state_ff, state_in;
   logic [bcpd_pkg::STEP_CNT_W-1:0]     step_ff, step_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcpd_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      req_stall     = 1'b1;
      unique case (state_ff)
         bcpd_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && sts.emit) begin
               state_in = bcpd_pkg::ST_DIV;
               step_in  = '0;
            end
         end
         bcpd_pkg::ST_DIV: begin
            if (step_ff == '0) begin
               cmd.div_first = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == bcpd_pkg::STEP_CNT_W'(bcpd_pkg::DIV_STEPS)) begin
               state_in = bcpd_pkg::ST_DONE;
            end
         end
         bcpd_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = bcpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcpd_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

endmodule

// ===== hdl/bcpd_datapath.sv =====
// datapath: config registers, run sums, three-lane serial divider, result register
module bcpd_datapath #(
   parameter int MAX_GROUP = 65535
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic                    csr_index,
   input  logic [15:0]             csr_write_data,
   input  logic [7:0]              req_byte_value,
   input  logic                    req_end_of_data,
   input  bcpd_pkg::ctrl_cmd_type  cmd,
   output bcpd_pkg::dp_status_type sts,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic [23:0]             rsp_pixel_index
);

   localparam int SW = bcpd_pkg::SUM_W;
   localparam int CW = bcpd_pkg::COUNT_W;
   localparam int NL = bcpd_pkg::NUM_LANES;

   logic [CW-1:0]                   group_size_ff;
   logic                            class_mode_ff;
   logic [SW-1:0]                   sum_ff [NL];
   logic [SW-1:0]                   sum_new [NL];
   logic [CW-1:0]                   run_count_ff;
   logic [bcpd_pkg::INDEX_W-1:0]    next_pixel_ff;

   logic [CW-1:0]                   rem_ff [NL];
   logic [CW-1:0]                   rem_in [NL];
   logic [7:0]                      quo_ff [NL];
   logic [7:0]                      quo_in [NL];
   logic                            ovf_ff [NL];
   logic [7:0]                      chan [NL];
   logic [CW-1:0]                   divisor_ff;
   logic                            mode_ff;
   logic [bcpd_pkg::INDEX_W-1:0]    index_ff;

   bcpd_pkg::lane_add_type          add;
   logic [CW-1:0]                   count_next;
   logic [23:0]                     eff_size;
   logic [CW:0]                     trial [NL];

   // effective group size: zero counts as one, saturate at the maximum
   always_comb begin
      if (group_size_ff == '0) begin
         eff_size = 24'd1;
      end else if ({8'd0, group_size_ff} > 24'(MAX_GROUP)) begin
         eff_size = 24'(MAX_GROUP);
      end else begin
         eff_size = {8'd0, group_size_ff};
      end
   end

   always_comb begin
      if (class_mode_ff) begin
         add = bcpd_pkg::class_add(req_byte_value);
      end else begin
         add = '0;
         add[bcpd_pkg::LANE_GREEN] = req_byte_value;
      end
      for (int i = 0; i < NL; i++) begin
         sum_new[i] = sum_ff[i] + SW'(add[i]);
      end
      count_next = run_count_ff + 1'b1;
      sts.emit   = req_end_of_data || (count_next == '0) ||
                   ({8'd0, count_next} >= eff_size);
   end

   // one restoring step per lane: shift in the next dividend bit, subtract if it fits
   always_comb begin
      for (int i = 0; i < NL; i++) begin
         trial[i]  = {rem_ff[i], quo_ff[i][7]};
         if (trial[i] >= {1'b0, divisor_ff}) begin
            rem_in[i] = CW'(trial[i] - {1'b0, divisor_ff});
            quo_in[i] = {quo_ff[i][6:0], 1'b1};
         end else begin
            rem_in[i] = trial[i][CW-1:0];
            quo_in[i] = {quo_ff[i][6:0], 1'b0};
         end
         chan[i] = ovf_ff[i] ? bcpd_pkg::CHAN_MAX : quo_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= 16'd1;
         class_mode_ff <= 1'b1;
         run_count_ff  <= '0;
         next_pixel_ff <= '0;
         for (int i = 0; i < NL; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               bcpd_pkg::CSR_GROUP_SIZE: group_size_ff <= csr_write_data;
               bcpd_pkg::CSR_CLASS_MODE: class_mode_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            if (sts.emit) begin
               run_count_ff  <= '0;
               next_pixel_ff <= req_end_of_data ? '0 : next_pixel_ff + 1'b1;
               for (int i = 0; i < NL; i++) begin
                  sum_ff[i] <= '0;
               end
            end else begin
               run_count_ff <= count_next;
               for (int i = 0; i < NL; i++) begin
                  sum_ff[i] <= sum_new[i];
               end
            end
         end
      end
   end

   // divider lanes and result register carry no reset
   always_ff @(posedge clock) begin
      if (cmd.accept && sts.emit) begin
         divisor_ff <= (count_next == '0) ? CW'(1) : count_next;
         mode_ff    <= class_mode_ff;
         index_ff   <= next_pixel_ff;
         for (int i = 0; i < NL; i++) begin
            rem_ff[i] <= sum_new[i][SW-1:8];
            quo_ff[i] <= sum_new[i][7:0];
         end
      end
      if (cmd.div_first) begin
         for (int i = 0; i < NL; i++) begin
            ovf_ff[i] <= rem_ff[i] >= divisor_ff;
         end
      end
      if (cmd.div_step) begin
         for (int i = 0; i < NL; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
      if (cmd.out_load) begin
         rsp_red         <= mode_ff ? chan[bcpd_pkg::LANE_RED] : bcpd_pkg::PLAIN_FILL;
         rsp_green       <= chan[bcpd_pkg::LANE_GREEN];
         rsp_blue        <= mode_ff ? chan[bcpd_pkg::LANE_BLUE] : bcpd_pkg::PLAIN_FILL;
         rsp_pixel_index <= index_ff;
      end
   end

endmodule
